/* rtl/counter_matrix_accumulate_dump_macros.svh */
// assertion macros shared by the counter matrix rtl
// expects a clock named clk and a synchronous reset named rst in the including module
`ifndef COUNTER_MATRIX_ACCUMULATE_DUMP_MACROS_SVH
`define COUNTER_MATRIX_ACCUMULATE_DUMP_MACROS_SVH

// property checked on every edge outside reset
`define CMAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent on one edge, consequent on the next
`define CMAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cmad_pkg.sv */
// types and codes for the counter matrix accumulate and dump block
// no dependencies
package cmad_pkg;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_SUB  = 2'd1;
  localparam logic [1:0] FUNC_DUMP = 2'd2;

  localparam logic [0:0] REG_SCALE   = 1'b0;
  localparam logic [0:0] REG_DIVISOR = 1'b1;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] amount;
    logic              mirror;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic [DATA_W-1:0] value;
    logic              empty_res;
    logic              last;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_UPD_RD,
    S_UPD_WAIT,
    S_DUMP_RD,
    S_DUMP_CHK,
    S_DIV,
    S_DUMP_PUSH,
    S_DUMP_END
  } state_t;

endpackage

/* rtl/cmad_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module cmad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/counter_matrix_accumulate_dump.sv */
// counter matrix accumulate and dump, top level
// depends on cmad_pkg, cmad_ram and counter_matrix_accumulate_dump_macros.svh
//
// a SIDE x SIDE table of 32-bit counters held in one ram. after reset the block
// runs a clearing pass over all SIDE*SIDE entries (4096 at the default) with
// in_stall high; config writes are taken throughout. an add or subtract beat
// runs a multiply step (amount times scale, for a subtract only), then a read
// and a write of the ram, and with mirror set a second read and write, since
// each position is its own read-modify-write on the single ram port pair. a
// dump beat reads the row one column at a time and runs each nonzero entry
// through a single one-bit-per-cycle restoring divider, so it lasts longer
// with more nonzero entries, plus any time the output side stalls.
// results of a dump are held back by one entry so that last can be flagged; the
// output register lets the next beat be accepted while a result waits.
module counter_matrix_accumulate_dump #(
  parameter int SIDE = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cmad_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cmad_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  import cmad_pkg::*;

  `include "counter_matrix_accumulate_dump_macros.svh"

  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int DCW   = $clog2(DATA_W);

  state_t state, state_next;

  // latched item and config
  in_t               item;
  logic [DATA_W-1:0] scale;
  logic [DATA_W-1:0] divisor;
  logic [DATA_W-1:0] delta;

  // sequencer counters
  logic          pidx;
  logic [CW-1:0] ccnt;
  logic [AW-1:0] clr;
  logic [DCW-1:0] dcnt;

  // divider
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  // held-back result of a dump
  logic              pend_valid;
  logic [CW-1:0]     pend_col;
  logic [DATA_W-1:0] pend_val;

  // ram
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] rdata;

  // update position
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] pos_c;
  logic             pos_ok;
  logic [AW-1:0]    pos_addr;
  logic             col_last;
  logic             out_free;
  logic             out_load;
  logic             dump_busy;
  logic             accept;

  cmad_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // a new result beat enters the output register
  assign out_load = (state == S_DUMP_PUSH && pend_valid && out_free) ||
                    (state == S_DUMP_END && out_free);
  assign dump_busy = state inside {S_DUMP_RD, S_DUMP_CHK, S_DIV, S_DUMP_PUSH, S_DUMP_END};

  // first position is (row,col), the mirrored one (col,row)
  assign pos_r  = pidx ? item.col : item.row;
  assign pos_c  = pidx ? item.row : item.col;
  assign pos_ok = ({1'b0, pos_r} < 7'(SIDE)) && ({1'b0, pos_c} < 7'(SIDE));
  assign pos_addr = AW'(int'(pos_r) * SIDE + int'(pos_c));

  assign col_last = ccnt == CW'(SIDE - 1);

  // one restoring step of the divider, a zero divisor gives all ones
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_ADD || in_data.func == FUNC_SUB) begin
            state_next = S_MUL;
          end else if (in_data.func == FUNC_DUMP) begin
            state_next = ({1'b0, in_data.row} < 7'(SIDE)) ? S_DUMP_RD : S_DUMP_END;
          end
        end
      end
      S_MUL: state_next = S_UPD_RD;
      S_UPD_RD: begin
        if (pos_ok) state_next = S_UPD_WAIT;
        else if (!pidx && item.mirror) state_next = S_UPD_RD;
        else state_next = S_IDLE;
      end
      S_UPD_WAIT: begin
        state_next = (!pidx && item.mirror) ? S_UPD_RD : S_IDLE;
      end
      S_DUMP_RD: state_next = S_DUMP_CHK;
      S_DUMP_CHK: begin
        if (rdata != '0) state_next = S_DIV;
        else if (col_last) state_next = S_DUMP_END;
        else state_next = S_DUMP_RD;
      end
      S_DIV: begin
        if (dcnt == DCW'(DATA_W - 1)) state_next = S_DUMP_PUSH;
      end
      S_DUMP_PUSH: begin
        if (!pend_valid || out_free) state_next = col_last ? S_DUMP_END : S_DUMP_RD;
      end
      S_DUMP_END: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = pos_addr;
    ram_wdata = (item.func == FUNC_SUB) ? rdata - delta : rdata + delta;
    ram_re    = 1'b0;
    ram_raddr = pos_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
      end
      S_IDLE:     in_stall = 1'b0;
      S_UPD_RD:   ram_re = pos_ok;
      S_UPD_WAIT: ram_we = 1'b1;
      S_DUMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(int'(item.row) * SIDE + int'(ccnt));
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      scale      <= DATA_W'(1);
      divisor    <= DATA_W'(1);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + AW'(1);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE:   scale   <= cfg_data;
          REG_DIVISOR: divisor <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_DUMP_PUSH && (!pend_valid || out_free)) pend_valid <= 1'b1;
      if (state == S_DUMP_END && out_free) pend_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
      pidx <= 1'b0;
      ccnt <= '0;
    end
    if (state == S_MUL) begin
      delta <= (item.func == FUNC_SUB) ? item.amount * scale : item.amount;
    end
    if ((state == S_UPD_RD || state == S_UPD_WAIT) && state_next == S_UPD_RD) begin
      pidx <= 1'b1;
    end
    if (state != S_IDLE && state_next == S_DUMP_RD) ccnt <= ccnt + CW'(1);
    if (state == S_DUMP_CHK) begin
      rem  <= '0;
      quo  <= rdata;
      dcnt <= '0;
    end
    if (state == S_DIV) begin
      dcnt <= dcnt + DCW'(1);
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
    if (state == S_DUMP_PUSH && (!pend_valid || out_free)) begin
      pend_col <= ccnt;
      pend_val <= quo;
      if (pend_valid) begin
        out_data <= '{out_row: item.row, out_col: IDX_W'(pend_col), value: pend_val,
                      empty_res: 1'b0, last: 1'b0};
      end
    end
    if (state == S_DUMP_END && out_free) begin
      if (pend_valid) begin
        out_data <= '{out_row: item.row, out_col: IDX_W'(pend_col), value: pend_val,
                      empty_res: 1'b0, last: 1'b1};
      end else begin
        out_data <= '{out_row: item.row, out_col: '0, value: '0,
                      empty_res: 1'b1, last: 1'b1};
      end
    end
  end

  `CMAD_ASSERT(a_clear_stalls, state != S_CLEAR || in_stall, "input taken during clearing pass")
  `CMAD_ASSERT(a_pend_in_dump, !pend_valid || dump_busy, "held result outside a dump")
  `CMAD_ASSERT_NEXT(a_div_start, state == S_DUMP_CHK && rdata != '0, state == S_DIV, "no divide")
  `CMAD_ASSERT(a_empty_last, !(out_valid && out_data.empty_res) || out_data.last, "empty no last")

endmodule
